[hdl/gnpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnpg_pkg
// shared types, constants and table builders for the noise pixel generator
// ----------------------------------------------------------------------------
package gnpg_pkg;

    localparam int          LUT_ADDR_BITS_DEF = 10;
    localparam logic [63:0] LCG_MUL           = 64'd6364136223846793005;
    localparam logic [63:0] LCG_ADD           = 64'd1442695040888963407;
    localparam logic [63:0] TWO_LN2_Q30       = 64'd1488522236;
    localparam logic [63:0] HALF_PI_Q30       = 64'd1686629713;
    localparam logic [15:0] ZERO_U_RADIUS     = 16'd30449;
    localparam logic [63:0] SEED_RESET        = 64'd1;
    localparam logic [7:0]  BACKGROUND_RESET  = 8'd22;
    localparam logic [11:0] SIGMA_RESET       = 12'd48;

    localparam logic [1:0]  REG_SEED       = 2'd0;
    localparam logic [1:0]  REG_BACKGROUND = 2'd1;
    localparam logic [1:0]  REG_SIGMA      = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_ADD1,
        ST_MUL2,
        ST_ADD2,
        ST_LOOKUP,
        ST_MULR,
        ST_MULS,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic load_seed;
        logic lcg_mul;
        logic lcg_add;
        logic keep_f1;
        logic lookup;
        logic mul_r;
        logic mul_s;
        logic finish;
    } cmd_t;

    function automatic logic [63:0] log2_q24(input logic [31:0] m);
        logic [63:0] x;
        logic [63:0] frac;
        int          e;
        frac = 64'd0;
        e = 0;
        while (e < 31 && (m >> (e + 1)) != 32'd0)
            e++;
        x = {32'd0, m} << (30 - e);
        for (int b = 23; b >= 0; b--)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30))
            begin
                x = x >> 1;
                frac = frac | (64'd1 << b);
            end
        end
        return (64'(e) << 24) + frac;
    endfunction

    function automatic logic [15:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_w;
        v = v_in;
        res = 64'd0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w = bit_w >> 2;
        while (bit_w != 64'd0)
        begin
            if (v >= res + bit_w)
            begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end
            else
                res = res >> 1;
            bit_w = bit_w >> 2;
        end
        return res[15:0];
    endfunction

    // restoring long division, truncating quotient
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = 64'd0;
        r = 65'd0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den})
            begin
                r = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [13:0] quarter_cos(input int k, input int abits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] dv;
        x = (64'(k) * HALF_PI_Q30) >> (abits - 2);
        x2 = (x * x) >> 30;
        term = 64'd1 << 30;
        sum = $signed(term);
        for (int n = 1; n <= 9; n++)
        begin
            dv = 64'((2 * n - 1) * (2 * n));
            term = udiv64((term * x2) >> 30, dv);
            if (n[0])
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        return 14'((64'(sum) + (64'd1 << 17)) >> 18);
    endfunction

    function automatic logic [15:0] rad_entry(input int i, input int abits);
        logic [63:0] l;
        logic [63:0] v;
        l = (64'(abits + 1) << 24) - log2_q24(32'(2 * i + 1));
        v = (l * TWO_LN2_Q30 + (64'd1 << 29)) >> 30;
        return isqrt64(v);
    endfunction

    function automatic logic signed [13:0] cos_entry(input int i, input int abits);
        int quad;
        int q;
        int quarter;
        quarter = 1 << (abits - 2);
        quad = i >> (abits - 2);
        q = i & (quarter - 1);
        case (quad)
            0:       return $signed(quarter_cos(q, abits));
            1:       return -$signed(quarter_cos(quarter - q, abits));
            2:       return -$signed(quarter_cos(q, abits));
            default: return $signed(quarter_cos(quarter - q, abits));
        endcase
    endfunction

endpackage

[hdl/gnpg_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnpg_ctrl
// sequencer for the two generator steps, table read, scaling and output beat
// ----------------------------------------------------------------------------
module gnpg_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          reseed,
    output logic          out_valid,
    input  logic          out_stall,
    output gnpg_pkg::cmd_t cmd
);
    import gnpg_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   fin_ok;

    assign fin_ok = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.load_seed = reseed;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.lcg_mul = 1'b1;
                state_next = ST_ADD1;
            end
            ST_ADD1:
            begin
                cmd.lcg_add = 1'b1;
                cmd.keep_f1 = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.lcg_mul = 1'b1;
                state_next = ST_ADD2;
            end
            ST_ADD2:
            begin
                cmd.lcg_add = 1'b1;
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_MULR;
            end
            ST_MULR:
            begin
                cmd.mul_r = 1'b1;
                state_next = ST_MULS;
            end
            ST_MULS:
            begin
                cmd.mul_s = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (fin_ok)
                begin
                    cmd.finish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && fin_ok) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished beat not presented");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && state_reg != ST_FIN) |=> out_valid_reg)
        else $error("stalled output beat dropped");
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_MUL1))
        else $error("accepted beat did not start generator");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish) |-> (!out_valid_reg || !out_stall))
        else $error("result overwrote a waiting beat");

endmodule

[hdl/gnpg_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnpg_datapath
// lcg state, box-muller tables, scaling and clamp
// ----------------------------------------------------------------------------
module gnpg_datapath #(
    parameter int LUT_ADDR_BITS = gnpg_pkg::LUT_ADDR_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  gnpg_pkg::cmd_t cmd,
    input  logic [63:0]    seed_value,
    input  logic [7:0]     background_level,
    input  logic [11:0]    noise_sigma,
    output logic [7:0]     pixel,
    output logic           clipped
);
    import gnpg_pkg::*;

    localparam int N = 1 << LUT_ADDR_BITS;

    typedef logic        [15:0] rad_arr_t [N];
    typedef logic signed [13:0] cos_arr_t [N];

    function automatic rad_arr_t build_rad();
        rad_arr_t t;
        for (int i = 0; i < N; i++)
            t[i] = rad_entry(i, LUT_ADDR_BITS);
        return t;
    endfunction

    function automatic cos_arr_t build_cos();
        cos_arr_t t;
        for (int i = 0; i < N; i++)
            t[i] = cos_entry(i, LUT_ADDR_BITS);
        return t;
    endfunction

    localparam rad_arr_t RAD_TAB = build_rad();
    localparam cos_arr_t COS_TAB = build_cos();

    logic [63:0] rng_reg;
    logic [63:0] p0_reg;
    logic [31:0] p1_reg, p2_reg;
    logic [63:0] rng_next;
    logic [LUT_ADDR_BITS-1:0] a1_reg;
    logic        f1_zero_reg;
    logic [15:0] rad_q;
    logic signed [13:0] cos_q;
    logic [14:0] mag_reg;
    logic        neg_reg;
    logic [26:0] scaled_reg;
    logic [7:0]  pixel_reg;
    logic        clipped_reg;
    logic [15:0] r_sel;
    logic [12:0] cmag;
    logic [28:0] rc_prod;
    logic signed [28:0] t_val;

    // low 64 bits of the product from three 32-bit partial products
    assign rng_next = p0_reg + {p1_reg + p2_reg, 32'd0} + LCG_ADD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rng_reg <= SEED_RESET;
        else if (cmd.load && cmd.load_seed)
            rng_reg <= seed_value;
        else if (cmd.lcg_add)
            rng_reg <= rng_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lcg_mul)
        begin
            p0_reg <= 64'(rng_reg[31:0]) * 64'(LCG_MUL[31:0]);
            p1_reg <= 32'(rng_reg[63:32] * LCG_MUL[31:0]);
            p2_reg <= 32'(rng_reg[31:0] * LCG_MUL[63:32]);
        end
        if (cmd.keep_f1)
        begin
            a1_reg      <= rng_next[63 -: LUT_ADDR_BITS];
            f1_zero_reg <= (rng_next[63:33] == 31'd0);
        end
        if (cmd.lookup)
        begin
            rad_q <= RAD_TAB[a1_reg];
            cos_q <= COS_TAB[rng_reg[63 -: LUT_ADDR_BITS]];
        end
        if (cmd.mul_r)
        begin
            mag_reg <= rc_prod[26:12];
            neg_reg <= cos_q[13];
        end
        if (cmd.mul_s)
            scaled_reg <= 27'(mag_reg * noise_sigma);
        if (cmd.finish)
        begin
            if (t_val < 0)
            begin
                pixel_reg   <= 8'd0;
                clipped_reg <= 1'b1;
            end
            else if (t_val > $signed(29'(32'd255 << 16)))
            begin
                pixel_reg   <= 8'd255;
                clipped_reg <= 1'b1;
            end
            else
            begin
                pixel_reg   <= t_val[23:16];
                clipped_reg <= 1'b0;
            end
        end
    end

    assign r_sel   = f1_zero_reg ? ZERO_U_RADIUS : rad_q;
    assign cmag    = cos_q[13] ? 13'(-cos_q) : cos_q[12:0];
    assign rc_prod = 29'(r_sel * cmag);
    assign t_val   = neg_reg ? $signed({5'd0, background_level, 16'd0}) - $signed({2'd0, scaled_reg})
                             : $signed({5'd0, background_level, 16'd0}) + $signed({2'd0, scaled_reg});

    assign pixel   = pixel_reg;
    assign clipped = clipped_reg;

endmodule

[hdl/gaussian_noise_pixel_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_noise_pixel_generator
// sky background pixel: background plus box-muller gaussian noise
// ----------------------------------------------------------------------------
// sequence: an accepted input beat runs two lcg steps (multiply, then add) one after
//   the other, then table read and two scaling multiplies; no new beat is taken
//   until the finished beat is presented, and finishing waits on a stalled output
// reset: config registers take their reset values, generator state = 1,
//   no pending beat; tables are constant roms, no clearing pass
module gaussian_noise_pixel_generator #(
    parameter int LUT_ADDR_BITS = gnpg_pkg::LUT_ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        reseed,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pixel,
    output logic        clipped
);
    import gnpg_pkg::*;

    logic [63:0] seed_reg;
    logic [7:0]  background_reg;
    logic [11:0] sigma_reg;
    cmd_t        cmd;

    // configuration registers, out of range index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg       <= SEED_RESET;
            background_reg <= BACKGROUND_RESET;
            sigma_reg      <= SIGMA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SEED:       seed_reg       <= cfg_data;
                REG_BACKGROUND: background_reg <= cfg_data[7:0];
                REG_SIGMA:      sigma_reg      <= cfg_data[11:0];
                default:        ;
            endcase
        end
    end

    // sequencer
    gnpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .reseed    (reseed),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // generator, tables and pixel arithmetic
    gnpg_datapath #(
        .LUT_ADDR_BITS (LUT_ADDR_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .seed_value       (seed_reg),
        .background_level (background_reg),
        .noise_sigma      (sigma_reg),
        .pixel            (pixel),
        .clipped          (clipped)
    );

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the gaussian noise pixel generator: a local model of the lcg,
// box-muller tables and pixel clamp predicts every output beat
// ----------------------------------------------------------------------------
module tb;
    import gnpg_pkg::*;

    localparam int ABITS   = LUT_ADDR_BITS_DEF;
    localparam int NTAB    = 1 << ABITS;
    localparam int QTR     = NTAB >> 2;
    localparam int LATENCY = 9;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        reseed;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  pixel;
    logic        clipped;

    gaussian_noise_pixel_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .reseed    (reseed),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel     (pixel),
        .clipped   (clipped)
    );

    typedef struct packed {
        logic [7:0] pixel;
        logic       clipped;
    } pix_t;

    // model copy of registers and generator state
    logic [63:0] seed_q;
    logic [7:0]  bg_q;
    logic [11:0] sigma_q;
    logic [63:0] lcg_q;

    logic [15:0] radius_rom [NTAB];
    int          cosine_rom [NTAB];

    pix_t expected_pixels[$];
    int   mismatch_count;
    bit   long_hold;
    int   stall_pct;

    // ------------------------------------------------------------------
    // local integer model of the tables
    // ------------------------------------------------------------------
    function automatic logic [63:0] log2_fix(input logic [31:0] m);
        logic [63:0] x;
        logic [63:0] fr;
        int          msb;
        fr = 0;
        msb = 0;
        while (msb < 31 && (m >> (msb + 1)) != 0)
            msb++;
        x = {32'd0, m} << (30 - msb);
        for (int b = 23; b >= 0; b--)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31))
            begin
                x = x >> 1;
                fr[b] = 1'b1;
            end
        end
        return (64'(msb) << 24) + fr;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bw;
        v = v_in;
        r = 0;
        bw = 64'd1 << 62;
        while (bw > v)
            bw = bw >> 2;
        while (bw != 0)
        begin
            if (v >= r + bw)
            begin
                v = v - (r + bw);
                r = (r >> 1) + bw;
            end
            else
                r = r >> 1;
            bw = bw >> 2;
        end
        return r;
    endfunction

    function automatic int cos_quarter(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        x = (64'(k) * HALF_PI_Q30) >> (ABITS - 2);
        x2 = (x * x) >> 30;
        term = 64'd1 << 30;
        acc = longint'(term);
        for (int n = 1; n <= 9; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        return int'((64'(acc) + (64'd1 << 17)) >> 18);
    endfunction

    task automatic build_noise_tables();
        logic [63:0] l;
        logic [63:0] v;
        int          q;
        for (int i = 0; i < NTAB; i++)
        begin
            l = (64'(ABITS + 1) << 24) - log2_fix(32'(2 * i + 1));
            v = (l * TWO_LN2_Q30 + (64'd1 << 29)) >> 30;
            radius_rom[i] = 16'(int_sqrt(v));
            q = i & (QTR - 1);
            case (i >> (ABITS - 2))
                0:       cosine_rom[i] = cos_quarter(q);
                1:       cosine_rom[i] = -cos_quarter(QTR - q);
                2:       cosine_rom[i] = -cos_quarter(q);
                default: cosine_rom[i] = cos_quarter(QTR - q);
            endcase
        end
    endtask

    function automatic logic [30:0] lcg_advance();
        lcg_q = lcg_q * LCG_MUL + LCG_ADD;
        return lcg_q[63:33];
    endfunction

    // predicts one pixel from the model state and advances it
    function automatic pix_t predict_pixel(input logic rs);
        logic [30:0] f1;
        logic [30:0] f2;
        logic [63:0] rad;
        logic [63:0] cmag;
        logic [63:0] mag;
        longint      t;
        int          c;
        pix_t        p;
        if (rs)
            lcg_q = seed_q;
        f1 = lcg_advance();
        f2 = lcg_advance();
        rad = (f1 == 0) ? 64'(ZERO_U_RADIUS) : 64'(radius_rom[f1[30 -: ABITS]]);
        c = cosine_rom[f2[30 -: ABITS]];
        cmag = (c < 0) ? 64'(-c) : 64'(c);
        mag = ((rad * cmag) >> 12) * 64'(sigma_q);
        t = longint'(bg_q) << 16;
        if (c < 0)
            t = t - longint'(mag);
        else
            t = t + longint'(mag);
        if (t < 0)
            p = '{8'd0, 1'b1};
        else if (t > (longint'(255) << 16))
            p = '{8'd255, 1'b1};
        else
            p = '{t[23:16], 1'b0};
        return p;
    endfunction

    // ------------------------------------------------------------------
    // clock, limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: random stall pattern, plus an optional long hold
    // ------------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // checker: each accepted output beat against the oldest expectation
    // ------------------------------------------------------------------
    initial
    begin
        pix_t want;
        mismatch_count = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("tb: unexpected beat pixel=%0d clipped=%0b",
                                 pixel, clipped);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (want.pixel !== pixel || want.clipped !== clipped)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("tb: mismatch pixel exp %0d got %0d, clipped exp %0b got %0b",
                                     want.pixel, pixel, want.clipped, clipped);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // shared tasks
    // ------------------------------------------------------------------

    // offers one beat and holds it until accepted; prediction at acceptance
    task automatic send_pixel_request(input logic rs);
        in_valid <= 1'b1;
        reseed   <= rs;
        do
            @(posedge clk);
        while (in_stall);
        expected_pixels.push_back(predict_pixel(rs));
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // bursts of random length with random gaps
    task automatic send_burst_stream(input int count, input int reseed_pct);
        int left;
        left = count;
        while (left > 0)
        begin
            for (int b = $urandom_range(12, 1); b > 0 && left > 0; b--)
            begin
                send_pixel_request($urandom_range(99) < reseed_pct);
                left--;
            end
            if ($urandom_range(3) != 0)
                idle_gap($urandom_range(20, 1));
        end
        idle_gap(1);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_SEED:       seed_q  = val;
            REG_BACKGROUND: bg_q    = val[7:0];
            REG_SIGMA:      sigma_q = val[11:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values, a few draws, reseed from default seed
    task automatic test_reset_defaults();
        for (int i = 0; i < 4; i++)
            send_pixel_request(1'b0);
        send_pixel_request(1'b1);
        send_pixel_request(1'b0);
        drain_results();
    endtask

    // register extremes: zero and full sigma, dark and bright background
    task automatic test_register_extremes();
        write_reg(REG_SIGMA, 64'd0);
        write_reg(REG_BACKGROUND, 64'd0);
        send_pixel_request(1'b0);
        drain_results();
        write_reg(REG_BACKGROUND, 64'd255);
        send_pixel_request(1'b0);
        drain_results();
        write_reg(REG_SIGMA, 64'hfff);
        write_reg(REG_BACKGROUND, 64'd128);
        for (int i = 0; i < 4; i++)
            send_pixel_request(1'b0);
        drain_results();
        write_reg(REG_SEED, 64'hffff_ffff_ffff_ffff);
        write_reg(REG_SEED, 64'hffff_ffff_ffff_ffff);
        send_pixel_request(1'b1);
        drain_results();
        write_reg(REG_SEED, 64'd0);
        // seed write alone leaves the generator state untouched
        send_pixel_request(1'b0);
        send_pixel_request(1'b1);
        drain_results();
    endtask

    // zero first fraction: pick a seed whose first step lands on zero
    task automatic test_zero_first_fraction();
        // seed s with s*MUL + ADD == 0 needs MUL inverse, computed below
        logic [63:0] inv;
        logic [63:0] s;
        inv = 64'd1;
        // newton iteration for inverse of odd multiplier mod 2^64
        for (int i = 0; i < 6; i++)
            inv = inv * (64'd2 - LCG_MUL * inv);
        s = (64'd0 - LCG_ADD) * inv;
        write_reg(REG_SEED, s);
        write_reg(REG_SIGMA, 64'd48);
        write_reg(REG_BACKGROUND, 64'd22);
        send_pixel_request(1'b1);
        drain_results();
        write_reg(REG_SIGMA, 64'h400);
        send_pixel_request(1'b1);
        drain_results();
    endtask

    // long receiver hold while the sender keeps offering
    task automatic test_backpressure();
        write_reg(REG_SEED, {$urandom, $urandom});
        fork
            begin
                long_hold = 1'b1;
                repeat (200) @(posedge clk);
                long_hold = 1'b0;
            end
            send_burst_stream(40, 5);
        join
        drain_results();
    endtask

    // random stream over several register settings
    task automatic test_random_stream();
        for (int phase = 0; phase < 16; phase++)
        begin
            write_reg(REG_SEED, {$urandom, $urandom});
            write_reg(REG_BACKGROUND, 64'($urandom_range(255)));
            case (phase % 4)
                0: write_reg(REG_SIGMA, 64'($urandom_range(4095)));
                1: write_reg(REG_SIGMA, 64'($urandom_range(200)));
                2: write_reg(REG_SIGMA, 64'd4095);
                default: write_reg(REG_SIGMA, 64'($urandom_range(64)));
            endcase
            write_reg(2'd3, {$urandom, $urandom});
            stall_pct = (phase % 3 == 0) ? 0 : $urandom_range(70);
            send_burst_stream(100, 3);
            drain_results();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_SEED;
        cfg_data  = 64'd0;
        in_valid  = 1'b0;
        reseed    = 1'b0;
        long_hold = 1'b0;
        stall_pct = 30;
        seed_q    = SEED_RESET;
        bg_q      = BACKGROUND_RESET;
        sigma_q   = SIGMA_RESET;
        lcg_q     = SEED_RESET;
        build_noise_tables();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_zero_first_fraction();
        test_backpressure();
        test_random_stream();

        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
